>>> sv/image_row_column_projection_core_defines.svh
// assertion macros shared by the projection core modules
`ifndef IMAGE_ROW_COLUMN_PROJECTION_CORE_DEFINES_SVH
`define IMAGE_ROW_COLUMN_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication
`define IRCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ircp_pkg.sv
// types, codes and sizes of the row and column projection core
package ircp_pkg;

   localparam int PIXEL_BITS         = 16;
   localparam int BIN_BITS           = 11;
   localparam int SUM_BITS           = 27;
   localparam int CFG_BITS           = 12;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int IDX_BITS           = 14;
   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [CFG_BITS-1:0] CFG_SIZE_RESET = 12'd2048;

   localparam logic [1:0] CMD_PIXEL    = 2'd0;
   localparam logic [1:0] CMD_READ_COL = 2'd1;
   localparam logic [1:0] CMD_READ_ROW = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [BIN_BITS-1:0]   bin_index;
   } ircp_req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] projection_sum;
      logic                index_out_of_range;
   } ircp_rsp_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic [1:0]            cmd;
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [IDX_BITS-1:0]   col_addr;
      logic [IDX_BITS-1:0]   row_addr;
      logic                  first_row;
      logic                  row_end;
      logic                  out_of_range;
   } ircp_op_type;

endpackage

>>> sv/ircp_ram.sv
// generic simple dual-port ram with registered read
module ircp_ram import ircp_pkg::*; #(
   parameter int WIDTH = SUM_BITS,
   parameter int DEPTH = MAX_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/ircp_queue.sv
// short operation queue between front and back
module ircp_queue import ircp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ircp_op_type push_op,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output ircp_op_type head_op
);

   `include "image_row_column_projection_core_defines.svh"

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   ircp_op_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   `IRCP_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !full,
      "queue pushed while full")

endmodule

>>> sv/ircp_front.sv
// request intake: configuration, raster position tracking and classification
module ircp_front import ircp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ircp_req_type              req,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data,
   input  logic                      queue_full,
   output logic                      push,
   output ircp_op_type               push_op
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [IDX_BITS-1:0] MAX_W = IDX_BITS'(MAX_WIDTH);
   localparam logic [IDX_BITS-1:0] MAX_H = IDX_BITS'(MAX_HEIGHT);

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;
   logic [CW-1:0]       col_pos_ff, col_pos_in;
   logic [RW-1:0]       row_pos_ff, row_pos_in;

   logic [IDX_BITS-1:0] w_cfg, h_cfg, w_eff, h_eff;
   logic [IDX_BITS-1:0] col_cur, row_cur, col_next, row_next, bin_ext;
   logic                row_end, frame_end, accept, is_pixel;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req.cmd == CMD_PIXEL);

   always_comb begin
      w_cfg = {{(IDX_BITS-CFG_BITS){1'b0}}, width_ff};
      h_cfg = {{(IDX_BITS-CFG_BITS){1'b0}}, height_ff};
      // zero acts as one, oversize acts as the maximum
      if (width_ff == '0) begin
         w_eff = IDX_BITS'(1);
      end else if (w_cfg > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = w_cfg;
      end
      if (height_ff == '0) begin
         h_eff = IDX_BITS'(1);
      end else if (h_cfg > MAX_H) begin
         h_eff = MAX_H;
      end else begin
         h_eff = h_cfg;
      end
   end

   always_comb begin
      col_cur   = IDX_BITS'(col_pos_ff);
      row_cur   = IDX_BITS'(row_pos_ff);
      col_next  = col_cur + 1'b1;
      row_next  = row_cur + 1'b1;
      row_end   = (col_next >= w_eff);
      frame_end = (row_next >= h_eff);
      bin_ext   = {{(IDX_BITS-BIN_BITS){1'b0}}, req.bin_index};
   end

   always_comb begin
      push_op             = '0;
      push_op.cmd         = req.cmd;
      push_op.pixel_value = req.pixel_value;
      push_op.first_row   = (row_cur == '0);
      push_op.row_end     = row_end;
      case (req.cmd)
         CMD_PIXEL: begin
            push_op.col_addr = col_cur;
            push_op.row_addr = row_cur;
         end
         CMD_READ_COL: begin
            push_op.col_addr     = bin_ext;
            push_op.out_of_range = (bin_ext >= w_eff);
         end
         CMD_READ_ROW: begin
            // rows are read back in reversed order
            push_op.row_addr     = h_eff - IDX_BITS'(1) - bin_ext;
            push_op.out_of_range = (bin_ext >= h_eff);
         end
         default: begin
            push_op.out_of_range = 1'b0;
         end
      endcase
      push = accept && (is_pixel || req.cmd == CMD_READ_COL || req.cmd == CMD_READ_ROW);
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_data;
            REG_IMAGE_HEIGHT: height_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
      if (accept && is_pixel) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = frame_end ? '0 : row_next[RW-1:0];
         end else begin
            col_pos_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_SIZE_RESET;
         height_ff  <= CFG_SIZE_RESET;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

endmodule

>>> sv/ircp_back.sv
// execution: projection memories, read-modify-write with forwarding, result register
module ircp_back import ircp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  ircp_op_type  head_op,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ircp_rsp_type rsp
);

   `include "image_row_column_projection_core_defines.svh"

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic                y_valid_ff, y_valid_in;
   ircp_op_type         y_op_ff, y_op_in;
   logic                y_fwd_col_ff, y_fwd_col_in;
   logic                y_fwd_row_ff, y_fwd_row_in;
   logic [SUM_BITS-1:0] y_fwd_col_data_ff, y_fwd_col_data_in;
   logic [SUM_BITS-1:0] y_fwd_row_data_ff, y_fwd_row_data_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ircp_rsp_type        rsp_ff, rsp_in;

   logic                advance, y_pixel, y_read;
   logic [SUM_BITS-1:0] pixel_ext, col_rdata, row_rdata, col_old, row_old;
   logic [SUM_BITS-1:0] col_wdata, acc_sum;
   logic                row_we;

   assign y_pixel   = y_valid_ff && (y_op_ff.cmd == CMD_PIXEL);
   assign y_read    = y_valid_ff && (y_op_ff.cmd != CMD_PIXEL);
   // only a read waiting on a full result register holds the stage
   assign advance   = !(y_read && rsp_valid_ff && !rsp_ready);
   assign pop       = advance && head_valid;

   assign pixel_ext = {{(SUM_BITS-PIXEL_BITS){1'b0}}, y_op_ff.pixel_value};
   assign col_old   = y_fwd_col_ff ? y_fwd_col_data_ff : col_rdata;
   assign row_old   = y_fwd_row_ff ? y_fwd_row_data_ff : row_rdata;
   assign col_wdata = y_op_ff.first_row ? pixel_ext : col_old + pixel_ext;
   assign acc_sum   = acc_ff + pixel_ext;
   assign row_we    = y_pixel && y_op_ff.row_end;

   ircp_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock (clock),
      .we    (y_pixel),
      .waddr (y_op_ff.col_addr[CW-1:0]),
      .wdata (col_wdata),
      .re    (pop),
      .raddr (head_op.col_addr[CW-1:0]),
      .rdata (col_rdata)
   );

   ircp_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_HEIGHT)
   ) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (y_op_ff.row_addr[RW-1:0]),
      .wdata (acc_sum),
      .re    (pop),
      .raddr (head_op.row_addr[RW-1:0]),
      .rdata (row_rdata)
   );

   always_comb begin
      y_valid_in        = y_valid_ff;
      y_op_in           = y_op_ff;
      y_fwd_col_in      = y_fwd_col_ff;
      y_fwd_row_in      = y_fwd_row_ff;
      y_fwd_col_data_in = y_fwd_col_data_ff;
      y_fwd_row_data_in = y_fwd_row_data_ff;
      if (advance) begin
         y_valid_in        = head_valid;
         y_op_in           = head_op;
         // the memory returns old data when written in the same cycle
         y_fwd_col_in      = pop && y_pixel &&
                             (head_op.col_addr[CW-1:0] == y_op_ff.col_addr[CW-1:0]);
         y_fwd_row_in      = pop && row_we && (head_op.cmd == CMD_READ_ROW) &&
                             (head_op.row_addr[RW-1:0] == y_op_ff.row_addr[RW-1:0]);
         y_fwd_col_data_in = col_wdata;
         y_fwd_row_data_in = acc_sum;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (y_pixel) begin
         acc_in = y_op_ff.row_end ? '0 : acc_sum;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (y_read && advance) begin
         rsp_valid_in = 1'b1;
         if (y_op_ff.out_of_range) begin
            rsp_in.projection_sum     = '0;
            rsp_in.index_out_of_range = 1'b1;
         end else begin
            rsp_in.projection_sum     = (y_op_ff.cmd == CMD_READ_COL) ? col_old : row_old;
            rsp_in.index_out_of_range = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_valid_ff   <= 1'b0;
         y_fwd_col_ff <= 1'b0;
         y_fwd_row_ff <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         y_valid_ff   <= y_valid_in;
         y_fwd_col_ff <= y_fwd_col_in;
         y_fwd_row_ff <= y_fwd_row_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_op_ff           <= y_op_in;
      y_fwd_col_data_ff <= y_fwd_col_data_in;
      y_fwd_row_data_ff <= y_fwd_row_data_in;
      rsp_ff            <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `IRCP_ASSERT_NOW(a_oor_sum_zero, clock, reset,
      rsp_valid_ff && rsp_ff.index_out_of_range, rsp_ff.projection_sum == '0,
      "out of range result carries a nonzero sum")
   `IRCP_ASSERT_NEXT(a_stalled_read_held, clock, reset,
      y_read && rsp_valid_ff && !rsp_ready, y_valid_ff && $stable(y_op_ff),
      "stalled read left the execute stage")
   `IRCP_ASSERT_NOW(a_row_fwd_on_row_read, clock, reset,
      y_fwd_row_ff, y_valid_ff && (y_op_ff.cmd == CMD_READ_ROW),
      "row forwarding flagged for an item that is not a row read")

endmodule

>>> sv/image_row_column_projection_core.sv
// a read request passes through the operation queue and the execute stage before its result is registered
// throughput: one request per cycle, pixels and reads alike, while the queue has room, set by the single
//   read-modify-write stage on the column memory (same-address hazards are forwarded)
// a result waiting on rsp_ready stalls only after the four-entry queue fills
// reset clears positions, row accumulator, queue and result valid, and sets both
//   sizes to 2048; projection memories are not cleared and hold data once written
module image_row_column_projection_core import ircp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ircp_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ircp_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   logic        queue_full, push, pop, head_valid;
   ircp_op_type push_op, head_op;

   ircp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   ircp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   ircp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp_data)
   );

endmodule

>>> tb/ircp_checker.sv
// projection predictor and result checker for the row and column projection core
`timescale 1ns / 1ps

module ircp_checker import ircp_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  ircp_req_type                    req,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  ircp_rsp_type                    rsp,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CFG_BITS-1:0]             csr_data,
   output int                              pending,
   output int                              fail_count,
   output logic [MAX_WIDTH_DEFAULT-1:0]    col_written,
   output logic [MAX_HEIGHT_DEFAULT-1:0]   row_written,
   output int                              frame_width,
   output int                              frame_height
);

   logic [SUM_BITS-1:0]           column_total [MAX_WIDTH_DEFAULT];
   logic [SUM_BITS-1:0]           row_total [MAX_HEIGHT_DEFAULT];
   logic [SUM_BITS-1:0]           row_acc;
   logic [MAX_WIDTH_DEFAULT-1:0]  col_seen;
   logic [MAX_HEIGHT_DEFAULT-1:0] row_seen;
   logic [CFG_BITS-1:0]           width_reg;
   logic [CFG_BITS-1:0]           height_reg;
   int                            col_pos;
   int                            row_pos;
   int                            errors = 0;
   ircp_rsp_type                  expected_bins [$];

   // zero acts as one, anything past the memory depth acts as the depth
   function automatic int effective_size(logic [CFG_BITS-1:0] value, int depth);
      if (value == 0) return 1;
      if (value > depth) return depth;
      return int'(value);
   endfunction

   function automatic void project_request(ircp_req_type item);
      int           w;
      int           h;
      int           c;
      int           r;
      ircp_rsp_type bin_result;
      w = effective_size(width_reg, MAX_WIDTH_DEFAULT);
      h = effective_size(height_reg, MAX_HEIGHT_DEFAULT);
      bin_result = '0;
      case (item.cmd)
         CMD_PIXEL: begin
            c = col_pos;
            r = row_pos;
            if (r == 0) begin
               column_total[c] = SUM_BITS'(item.pixel_value);
               col_seen[c] = 1'b1;
            end else begin
               column_total[c] = column_total[c] + SUM_BITS'(item.pixel_value);
            end
            row_acc = row_acc + SUM_BITS'(item.pixel_value);
            // row and frame end on reached or passed, sizes may shrink mid frame
            if (c + 1 >= w) begin
               row_total[r] = row_acc;
               row_seen[r] = 1'b1;
               row_acc = '0;
               col_pos = 0;
               row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
               col_pos = c + 1;
            end
         end
         CMD_READ_COL: begin
            if (item.bin_index < w) bin_result.projection_sum = column_total[item.bin_index];
            else bin_result.index_out_of_range = 1'b1;
            expected_bins = {expected_bins, bin_result};
         end
         CMD_READ_ROW: begin
            // row projection is read bottom up
            if (item.bin_index < h)
               bin_result.projection_sum = row_total[h - 1 - item.bin_index];
            else
               bin_result.index_out_of_range = 1'b1;
            expected_bins = {expected_bins, bin_result};
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      ircp_rsp_type want;
      if (reset) begin
         width_reg  = CFG_SIZE_RESET;
         height_reg = CFG_SIZE_RESET;
         row_acc    = '0;
         col_pos    = 0;
         row_pos    = 0;
         col_seen   = '0;
         row_seen   = '0;
         expected_bins.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_data;
            else if (csr_index == REG_IMAGE_HEIGHT) height_reg = csr_data;
         end
         if (req_valid && req_ready) project_request(req);
         if (rsp_valid && rsp_ready) begin
            if (expected_bins.size() == 0) begin
               $error("unexpected result: projection_sum %0d index_out_of_range %0b",
                      rsp.projection_sum, rsp.index_out_of_range);
               errors++;
            end else begin
               want = expected_bins.pop_front();
               if (rsp.projection_sum !== want.projection_sum) begin
                  $error("projection_sum: expected %0d, actual %0d",
                         want.projection_sum, rsp.projection_sum);
                  errors++;
               end
               if (rsp.index_out_of_range !== want.index_out_of_range) begin
                  $error("index_out_of_range: expected %0b, actual %0b",
                         want.index_out_of_range, rsp.index_out_of_range);
                  errors++;
               end
            end
         end
      end
      pending      <= expected_bins.size();
      fail_count   <= errors;
      col_written  <= col_seen;
      row_written  <= row_seen;
      frame_width  <= effective_size(width_reg, MAX_WIDTH_DEFAULT);
      frame_height <= effective_size(height_reg, MAX_HEIGHT_DEFAULT);
   end

endmodule

>>> tb/tb.sv
// stimulus and verdict for the row and column projection core
`timescale 1ns / 1ps

module tb import ircp_pkg::*;;

   localparam int              LIMIT_CYCLES     = 2_000_000;
   localparam int              SETTLE_CYCLES    = 8;
   localparam int              LONG_HOLD_CYCLES = 300;
   localparam int              RANDOM_PHASES    = 12;
   localparam int              ITEMS_PER_PHASE  = 45;
   localparam int              BURST_PIXELS     = 256;
   localparam logic [BIN_BITS-1:0]   BIN_TOP    = '1;
   localparam logic [1:0]      CMD_UNUSED       = 2'd3;
   localparam logic [PIXEL_BITS-1:0] PIXEL_TOP  = '1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   ircp_req_type              req = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   ircp_rsp_type              rsp;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_IMAGE_WIDTH;
   logic [CFG_BITS-1:0]       csr_data = '0;

   int                            pending;
   int                            fail_count;
   logic [MAX_WIDTH_DEFAULT-1:0]  col_written;
   logic [MAX_HEIGHT_DEFAULT-1:0] row_written;
   int                            frame_width;
   int                            frame_height;

   int cycle_count = 0;
   int hold_asks   = 0;
   bit steady      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   image_row_column_projection_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ircp_checker projection_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .pending      (pending),
      .fail_count   (fail_count),
      .col_written  (col_written),
      .row_written  (row_written),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 16) return PIXEL_TOP;
      return PIXEL_BITS'($urandom_range(0, PIXEL_TOP));
   endfunction

   function automatic logic [CFG_BITS-1:0] pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return CFG_BITS'($urandom_range(1, 10));
      if (roll < 88) return CFG_BITS'($urandom_range(11, 80));
      return CFG_BITS'($urandom_range(81, (1 << CFG_BITS) - 1));
   endfunction

   // receiver: random stalls, plus one long hold-off when asked for
   initial begin
      int hold_done;
      int gap;
      hold_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_done != hold_asks) begin
            hold_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [PIXEL_BITS-1:0] pixel,
                               input logic [BIN_BITS-1:0] bin_sel);
      ircp_req_type item;
      int           gap;
      item.cmd         = op;
      item.pixel_value = pixel;
      item.bin_index   = bin_sel;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // reads only bins that some pixel has already defined, or out of range ones
   task automatic send_random_read();
      logic [1:0]          op;
      logic [BIN_BITS-1:0] bin_sel;
      int                  limit;
      int                  k;
      int                  tries;
      bit                  found;
      op = $urandom_range(0, 1) ? CMD_READ_ROW : CMD_READ_COL;
      limit = (op == CMD_READ_ROW) ? frame_height : frame_width;
      found = 1'b0;
      if (limit <= BIN_TOP && $urandom_range(0, 4) == 0) begin
         bin_sel = BIN_BITS'($urandom_range(limit, BIN_TOP));
         found = 1'b1;
      end
      for (tries = 0; tries < 8 && !found; tries++) begin
         k = $urandom_range(0, limit - 1);
         found = (op == CMD_READ_ROW) ? row_written[limit - 1 - k] : col_written[k];
         bin_sel = BIN_BITS'(k);
      end
      if (found) send_request(op, random_pixel(), bin_sel);
      else send_request(CMD_PIXEL, random_pixel(), BIN_BITS'($urandom));
   endtask

   task automatic send_random_item();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) send_request(CMD_PIXEL, random_pixel(), BIN_BITS'($urandom));
      else if (roll < 97) send_random_read();
      else send_request(CMD_UNUSED, PIXEL_BITS'($urandom), BIN_BITS'($urandom));
   endtask

   // an extra wait after the writes so the checker's view of the sizes is current before requests
   task automatic write_sizes(input logic [CFG_BITS-1:0] width_value,
                              input logic [CFG_BITS-1:0] height_value);
      csr_valid <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data  <= width_value;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_data  <= height_value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, wait for every read to answer, then let pixels drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [CFG_BITS-1:0] wv;
      logic [CFG_BITS-1:0] hv;
      int                  p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // 3x2 frame with known content
      write_sizes(12'd3, 12'd2);
      send_request(CMD_PIXEL, PIXEL_TOP, BIN_TOP);
      send_request(CMD_PIXEL, 16'd0, 11'd0);
      send_request(CMD_PIXEL, 16'd1, 11'd0);
      send_request(CMD_PIXEL, 16'd2, 11'd0);
      send_request(CMD_PIXEL, PIXEL_TOP, 11'd0);
      send_request(CMD_PIXEL, 16'h1234, 11'd0);
      send_request(CMD_READ_COL, 16'd0, 11'd0);
      send_request(CMD_READ_COL, 16'd0, 11'd1);
      send_request(CMD_READ_COL, PIXEL_TOP, 11'd2);
      send_request(CMD_READ_COL, 16'd0, 11'd3);
      send_request(CMD_READ_COL, 16'd0, BIN_TOP);
      send_request(CMD_READ_ROW, 16'd0, 11'd0);
      send_request(CMD_READ_ROW, 16'd0, 11'd1);
      send_request(CMD_READ_ROW, 16'd0, 11'd2);
      send_request(CMD_READ_ROW, 16'd0, BIN_TOP);
      send_request(CMD_UNUSED, PIXEL_TOP, BIN_TOP);
      // next frame starts: column 0 is overwritten, row sums stay
      send_request(CMD_PIXEL, 16'd7, 11'd0);
      send_request(CMD_READ_COL, 16'd0, 11'd0);
      send_request(CMD_READ_ROW, 16'd0, 11'd1);
      settle();

      // long receiver hold-off while reads keep coming, fills the request queue
      steady = 1'b1;
      hold_asks++;
      repeat (40) send_random_read();
      settle();

      // long row of full-scale pixels, then a tall column of them
      write_sizes(CFG_BITS'(BURST_PIXELS), 12'd1);
      repeat (BURST_PIXELS) send_request(CMD_PIXEL, PIXEL_TOP, BIN_BITS'($urandom));
      send_request(CMD_READ_ROW, 16'd0, 11'd0);
      send_request(CMD_READ_ROW, 16'd0, 11'd1);
      send_request(CMD_READ_COL, 16'd0, 11'd0);
      send_request(CMD_READ_COL, 16'd0, BIN_TOP);
      settle();
      write_sizes(12'd1, CFG_BITS'(BURST_PIXELS));
      repeat (BURST_PIXELS) send_request(CMD_PIXEL, PIXEL_TOP, BIN_BITS'($urandom));
      send_request(CMD_READ_COL, 16'd0, 11'd0);
      send_request(CMD_READ_COL, 16'd0, 11'd1);
      send_request(CMD_READ_ROW, 16'd0, 11'd0);
      send_request(CMD_READ_ROW, 16'd0, BIN_TOP);
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               wv = '0;
               hv = '0;
            end
            1: begin
               wv = '1;
               hv = 12'd3;
            end
            2: begin
               wv = 12'd2;
               hv = '1;
            end
            3: begin
               wv = 12'd2049;
               hv = 12'd2;
            end
            default: begin
               wv = pick_size();
               hv = pick_size();
            end
         endcase
         write_sizes(wv, hv);
         steady = (p % 4 == 2);
         repeat (ITEMS_PER_PHASE) send_random_item();
         settle();
      end

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/ircp_pkg.sv
sv/ircp_ram.sv
sv/ircp_queue.sv
sv/ircp_front.sv
sv/ircp_back.sv
sv/image_row_column_projection_core.sv
tb/ircp_checker.sv
tb/tb.sv
